// ===== rtl/bsc_pkg.sv =====
// Package for the binary synchronous link controller: event, line, response codes,
// link states and the CRC-16 byte update. No dependencies.
`default_nettype none
package bsc_pkg;

    localparam int BLOCK_MAX_DEF  = 256;
    localparam int MAX_BLOCKS_DEF = 16;

    // input events
    localparam logic [4:0] EV_ENQ = 5'd1, EV_STX = 5'd2, EV_ETX = 5'd4,
        EV_ACK = 5'd5, EV_NAK = 5'd6, EV_TTD = 5'd7, EV_RVI = 5'd8, EV_WACK = 5'd9,
        EV_EOT = 5'd10, EV_DISC = 5'd11, EV_TICK = 5'd12, EV_HSEND = 5'd13,
        EV_HRECV = 5'd14, EV_HOPEN = 5'd15, EV_HDISC = 5'd16;

    // line codes
    localparam logic [3:0] LC_NONE = 4'd0, LC_ENQ = 4'd1, LC_NAK = 4'd2,
        LC_ACK0 = 4'd3, LC_ACK1 = 4'd4, LC_WACK = 4'd5, LC_RVI = 4'd6,
        LC_EOT = 4'd7, LC_DLEEOT = 4'd8, LC_TTD = 4'd9, LC_BLOCK = 4'd10;

    // response kinds
    localparam logic [3:0] RK_NORMAL = 4'd0, RK_NOTOPEN = 4'd1, RK_ALREADY = 4'd2,
        RK_RVI = 4'd3, RK_EOT = 4'd4, RK_ACKERR = 4'd5, RK_TIMEOUT = 4'd6,
        RK_RETRY = 4'd7, RK_SEND = 4'd8, RK_RECV = 4'd9, RK_OPENERR = 4'd10;

    // link states
    localparam logic [3:0] LS_CLOSED = 4'd0, LS_IDLE = 4'd1, LS_TXWAIT = 4'd2,
        LS_TEXT = 4'd3, LS_BID = 4'd4, LS_SENT = 4'd5, LS_ACKWAIT = 4'd6,
        LS_HOLD = 4'd7, LS_DONE = 4'd8;

    // host requests
    localparam logic [1:0] HR_NONE = 2'd0, HR_SEND = 2'd1, HR_RECV = 2'd2, HR_DISC = 2'd3;

    // timer actions
    localparam logic [1:0] TA_NONE = 2'd0, TA_STOP = 2'd1, TA_SHORT = 2'd2, TA_LONG = 2'd3;

    // config register indexes
    localparam logic [2:0] CR_BLEN = 3'd0, CR_SCNT = 3'd1, CR_TO = 3'd2, CR_TTD = 3'd3,
        CR_ACK = 3'd4, CR_NAK = 3'd5, CR_WBID = 3'd6, CR_WACK = 3'd7;

    typedef struct packed {
        logic [4:0] mode;
        logic [7:0] rx_byte;
        logic       ack_parity;
        logic [7:0] open_status;
    } t_event;

    typedef struct packed {
        logic [3:0] line_code;
        logic [3:0] block_index;
        logic       deliver_block;
        logic       response_valid;
        logic [3:0] response_kind;
        logic [3:0] response_state;
        logic [7:0] response_detail;
        logic [1:0] timer_action;
        logic       modem_close;
    } t_result;

    typedef struct packed {
        logic [8:0] block_length;
        logic [4:0] send_block_count;
        logic [7:0] timeout_limit;
        logic [7:0] ttd_limit;
        logic [7:0] ack_retry_limit;
        logic [7:0] nak_retry_limit;
        logic [7:0] wack_limit_bid;
        logic [7:0] wack_limit_ack_wait;
    } t_cfg;

    // reflected CRC-16 (0xA001), one byte, eight bit steps
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [7:0] sat15(input logic [5:0] v);
        return (v > 6'd15) ? 8'd15 : {2'd0, v};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/bsc_cfg_regs.sv =====
// Configuration register file of the link controller.
// Depends on bsc_pkg.
`default_nettype none
module bsc_cfg_regs
    import bsc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_wr,
    input  wire logic [2:0] i_idx,
    input  wire logic [8:0] i_data,
    output t_cfg            o_cfg
);
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{block_length: 9'd256, send_block_count: 5'd1, timeout_limit: 8'd8,
                       ttd_limit: 8'd8, ack_retry_limit: 8'd3, nak_retry_limit: 8'd3,
                       wack_limit_bid: 8'd8, wack_limit_ack_wait: 8'd8};
        end else if (i_wr) begin
            case (i_idx)
                CR_BLEN: r_cfg.block_length        <= i_data;
                CR_SCNT: r_cfg.send_block_count    <= i_data[4:0];
                CR_TO:   r_cfg.timeout_limit       <= i_data[7:0];
                CR_TTD:  r_cfg.ttd_limit           <= i_data[7:0];
                CR_ACK:  r_cfg.ack_retry_limit     <= i_data[7:0];
                CR_NAK:  r_cfg.nak_retry_limit     <= i_data[7:0];
                CR_WBID: r_cfg.wack_limit_bid      <= i_data[7:0];
                CR_WACK: r_cfg.wack_limit_ack_wait <= i_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule
`default_nettype wire

// ===== rtl/bsc_engine.sv =====
// Link state machine: one event a cycle while i_go is high, from the input port;
// next state and result combinational, receive store written. Depends on bsc_pkg.
`default_nettype none
module bsc_engine
    import bsc_pkg::*;
#(
    parameter int BLOCK_MAX  = BLOCK_MAX_DEF,
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_go,
    input  t_event       i_ev,
    input  t_cfg         i_cfg,
    output t_result      o_res
);
    localparam int PW = $clog2(BLOCK_MAX + 2);
    localparam int AW = $clog2(BLOCK_MAX);

    logic [3:0]  r_st, n_st;
    logic [1:0]  r_req, n_req;
    logic        r_enq, n_enq, r_rvi, n_rvi, r_exp, n_exp;
    logic [7:0]  r_to, n_to, r_ttd, n_ttd, r_ackc, n_ackc, r_nakc, n_nakc, r_wc, n_wc;
    logic [PW-1:0] r_ptr, n_ptr;
    logic [15:0] r_crc, n_crc;
    logic [4:0]  r_sent, n_sent;
    logic [3:0]  r_rcv, n_rcv;
    logic [3:0]  r_last, n_last;
    logic [7:0]  r_buf [BLOCK_MAX];
    logic        buf_we;
    t_result     res;

    always_ff @(posedge i_clk) begin
        if (i_go && buf_we) r_buf[r_ptr[AW-1:0]] <= i_ev.rx_byte;
    end

    // the store is written only; data kept for a host-side reader
    logic [4:0] blk_cap;
    assign blk_cap = (r_sent >= 5'(MAX_BLOCKS)) ? 5'(MAX_BLOCKS - 1) : r_sent;

    always_comb begin
        logic [4:0] ev;
        logic       ok;
        ev = i_ev.mode;
        ok = 1'b0;
        n_st = r_st; n_req = r_req; n_enq = r_enq; n_rvi = r_rvi; n_exp = r_exp;
        n_to = r_to; n_ttd = r_ttd; n_ackc = r_ackc; n_nakc = r_nakc; n_wc = r_wc;
        n_ptr = r_ptr; n_crc = r_crc; n_sent = r_sent; n_rcv = r_rcv; n_last = r_last;
        buf_we = 1'b0;
        res = '0;
        if (ev >= EV_ENQ && ev <= EV_HDISC) begin
            if (r_st == LS_CLOSED) begin
                if (ev == EV_TICK) res.timer_action = TA_STOP;
                else if (ev == EV_HSEND || ev == EV_HRECV) begin
                    res.response_valid = 1'b1; res.response_kind = RK_NOTOPEN;
                end else if (ev == EV_HOPEN) begin
                    res.response_valid = 1'b1;
                    if (i_ev.open_status == 8'd0) begin
                        n_st = LS_IDLE; n_req = HR_NONE; n_enq = 1'b0; n_rvi = 1'b0;
                        n_to = '0; n_sent = '0; n_rcv = '0; res.timer_action = TA_LONG;
                    end else begin
                        res.response_kind = RK_OPENERR; res.response_detail = i_ev.open_status;
                    end
                end else if (ev == EV_HDISC) res.response_valid = 1'b1;
            end else if (ev == EV_DISC) begin
                prog_end(r_req == HR_SEND ? RK_SEND : r_req == HR_RECV ? RK_RECV : RK_NORMAL,
                         r_req == HR_NONE);
            end else if (ev == EV_HOPEN) begin
                res.response_valid = 1'b1; res.response_kind = RK_ALREADY;
                res.response_state = r_st;
            end else if (ev == EV_HDISC) begin
                if (r_st >= LS_SENT && r_st <= LS_DONE) n_req = HR_DISC;
                else abort_line(RK_NORMAL);
            end else if (ev == EV_HSEND || ev == EV_HRECV) begin
                if (r_st == LS_IDLE) begin
                    if (ev == EV_HSEND) send_bid();
                    else begin
                        n_req = HR_RECV;
                        if (r_enq) begin
                            send_line(LC_ACK0); n_exp = 1'b1; n_st = LS_TXWAIT;
                            n_ttd = '0; n_enq = 1'b0; n_to = '0; res.timer_action = TA_LONG;
                        end
                    end
                end else begin
                    n_req = (ev == EV_HSEND) ? HR_SEND : HR_RECV;
                    if (r_st == LS_HOLD && r_enq) text_reply(n_req);
                    else if (r_st == LS_DONE && r_to == 8'd0) hold_nak(n_req);
                end
            end else begin
                case (r_st)
                    LS_IDLE: begin
                        if (ev == EV_ENQ) begin
                            if (r_req == HR_NONE) begin
                                n_enq = 1'b1; n_to = '0; res.timer_action = TA_SHORT;
                            end else begin
                                if (r_req == HR_SEND) send_line(LC_NAK);
                                else if (r_req == HR_RECV) begin
                                    send_line(LC_ACK0); n_exp = 1'b1;
                                    n_st = LS_TXWAIT; n_ttd = '0;
                                end
                                n_enq = 1'b0; n_to = '0; res.timer_action = TA_LONG;
                            end
                        end else if (ev == EV_TICK) tick_idle_wack();
                    end
                    LS_TXWAIT: begin
                        if (ev == EV_ENQ) begin
                            send_line(r_last); n_to = '0; res.timer_action = TA_LONG;
                        end else if (ev == EV_STX) begin
                            n_ptr = '0; n_crc = '0; n_st = LS_TEXT; n_to = '0;
                            res.timer_action = TA_LONG;
                        end else if (ev == EV_TTD) begin
                            if (r_ttd < i_cfg.ttd_limit) begin
                                send_line(LC_NAK); n_ttd = r_ttd + 8'd1; n_to = '0;
                                res.timer_action = TA_LONG;
                            end else abort_line(RK_RETRY);
                        end else if (ev == EV_EOT) begin
                            n_enq = 1'b0; n_rvi = 1'b0;
                            if (r_req == HR_SEND) send_bid();
                            else begin
                                if (r_req == HR_RECV) begin
                                    n_req = HR_NONE; res.response_valid = 1'b1;
                                end
                                to_idle();
                            end
                        end else if (ev == EV_TICK) tick_count();
                    end
                    LS_TEXT: begin
                        if (ev == EV_ENQ) begin
                            send_line(LC_NAK); n_st = LS_TXWAIT; n_to = '0; n_ttd = '0;
                            res.timer_action = TA_LONG;
                        end else if (ev == EV_ETX) begin
                            if (r_crc == 16'd0 && r_ptr == PW'(i_cfg.block_length)) begin
                                if (r_req == HR_NONE) begin
                                    n_enq = 1'b1; n_st = LS_HOLD; n_to = '0;
                                    res.timer_action = TA_SHORT;
                                end else text_reply(r_req);
                            end else begin
                                send_line(LC_NAK); n_st = LS_TXWAIT; n_enq = 1'b0;
                                n_ttd = '0; n_to = '0; res.timer_action = TA_LONG;
                            end
                        end else if (ev == EV_TICK) tick_count();
                        else begin
                            buf_we = (r_ptr < PW'(BLOCK_MAX));
                            if (r_ptr <= PW'(BLOCK_MAX)) n_ptr = r_ptr + PW'(1);
                            n_crc = crc16_byte(r_crc, i_ev.rx_byte);
                            n_to = '0; res.timer_action = TA_LONG;
                        end
                    end
                    LS_BID: begin
                        if (ev == EV_ACK) begin
                            if (!i_ev.ack_parity) begin
                                send_block(); n_exp = 1'b1; n_st = LS_SENT; n_to = '0;
                                n_ackc = '0; n_nakc = '0; n_wc = '0;
                                res.timer_action = TA_LONG;
                            end else begin
                                retry_enq(r_ackc, i_cfg.ack_retry_limit, ok);
                                if (ok) n_ackc = r_ackc + 8'd1;
                            end
                        end else if (ev == EV_NAK) begin
                            retry_enq(r_nakc, i_cfg.nak_retry_limit, ok);
                            if (ok) n_nakc = r_nakc + 8'd1;
                        end else if (ev == EV_RVI) rvi_received();
                        else if (ev == EV_WACK) begin
                            retry_enq(r_wc, i_cfg.wack_limit_bid, ok);
                            if (ok) n_wc = r_wc + 8'd1;
                        end else if (ev == EV_TICK) tick_send(LC_ENQ);
                    end
                    LS_SENT: begin
                        if (ev == EV_ACK) begin
                            if (i_ev.ack_parity == r_exp) ack_good();
                            else begin
                                send_line(LC_ENQ); n_st = LS_ACKWAIT; n_to = '0;
                                res.timer_action = TA_LONG;
                            end
                        end else if (ev == EV_NAK) nak_resend();
                        else if (ev == EV_RVI) rvi_received();
                        else if (ev == EV_WACK || ev == EV_TICK) begin
                            send_line(LC_ENQ); n_st = LS_ACKWAIT; n_to = '0;
                            res.timer_action = TA_LONG;
                        end else if (ev == EV_EOT) eot_received(HR_SEND);
                    end
                    LS_ACKWAIT: begin
                        if (ev == EV_ACK) begin
                            if (i_ev.ack_parity == r_exp) ack_good();
                            else begin
                                if (r_ackc < i_cfg.ack_retry_limit) begin
                                    send_block(); n_st = LS_SENT; n_ackc = r_ackc + 8'd1;
                                end else begin
                                    send_line(LC_EOT);
                                    res.response_valid = 1'b1; res.response_kind = RK_ACKERR;
                                    res.response_state = LS_ACKWAIT;
                                    res.response_detail = sat15({1'b0, r_sent} + 6'd1);
                                    n_st = LS_IDLE; n_enq = 1'b0;
                                end
                                n_to = '0; res.timer_action = TA_LONG;
                            end
                        end else if (ev == EV_NAK) nak_resend();
                        else if (ev == EV_RVI) rvi_received();
                        else if (ev == EV_WACK) begin
                            retry_enq(r_wc, i_cfg.wack_limit_ack_wait, ok);
                            if (ok) n_wc = r_wc + 8'd1;
                        end else if (ev == EV_EOT) eot_received(HR_SEND);
                        else if (ev == EV_TICK) tick_send(LC_ENQ);
                    end
                    LS_HOLD: begin
                        if (ev == EV_ENQ) begin
                            if (r_req == HR_NONE) begin
                                n_enq = 1'b1; res.timer_action = TA_SHORT;
                            end else text_reply(r_req);
                        end else if (ev == EV_EOT) eot_received(HR_RECV);
                        else if (ev == EV_TICK) tick_idle_wack();
                    end
                    LS_DONE: begin
                        if (ev == EV_NAK) hold_nak(r_req);
                        else if (ev == EV_EOT) eot_received(HR_SEND);
                        else if (ev == EV_TICK) tick_send(LC_TTD);
                    end
                    default: ;
                endcase
            end
        end
    end

    // helpers act on the next-state and result variables of the block above
    function automatic void send_line(input logic [3:0] c);
        res.line_code = c; n_last = c;
    endfunction

    function automatic void send_block();
        res.line_code = LC_BLOCK; res.block_index = blk_cap[3:0];
    endfunction

    function automatic void prog_end(input logic [3:0] kind, input logic quiet);
        if (!quiet) begin
            res.response_valid = 1'b1;
            if (!(kind == RK_NORMAL || r_req == HR_DISC)) begin
                res.response_kind = kind; res.response_state = r_st;
                if (r_req == HR_SEND) res.response_detail = sat15({1'b0, r_sent} + 6'd1);
                else if (r_req == HR_RECV)
                    res.response_detail = sat15({2'b0, r_rcv} + 6'd1);
            end
            n_req = HR_NONE;
        end
        res.modem_close = 1'b1; n_st = LS_CLOSED;
    endfunction

    function automatic void abort_line(input logic [3:0] kind);
        send_line(LC_DLEEOT); prog_end(kind, 1'b0);
    endfunction

    function automatic void to_idle();
        n_st = LS_IDLE; n_enq = 1'b0; n_to = '0; res.timer_action = TA_LONG;
    endfunction

    function automatic void send_bid();
        send_line(LC_ENQ); n_to = '0; n_ackc = '0; n_nakc = '0; n_wc = '0;
        n_exp = 1'b0; n_st = LS_BID; n_req = HR_SEND; res.timer_action = TA_LONG;
    endfunction

    function automatic void text_reply(input logic [1:0] req);
        if (req == HR_SEND) begin
            if (!r_rvi) begin
                send_line(LC_RVI); n_rvi = 1'b1; n_exp = ~r_exp;
            end else begin
                send_line(r_exp ? LC_ACK1 : LC_ACK0); n_exp = ~r_exp;
            end
        end else if (req == HR_RECV) begin
            send_line(r_exp ? LC_ACK1 : LC_ACK0); n_exp = ~r_exp;
            res.deliver_block = 1'b1;
            if (r_rcv < 4'd15) n_rcv = r_rcv + 4'd1;
        end
        n_st = LS_TXWAIT; n_enq = 1'b0; n_ttd = '0; n_to = '0; res.timer_action = TA_LONG;
    endfunction

    function automatic void hold_nak(input logic [1:0] req);
        if (req == HR_NONE) res.timer_action = TA_SHORT;
        else begin
            if (req == HR_SEND) begin
                send_block(); n_st = LS_SENT; n_ackc = '0; n_nakc = '0; n_wc = '0;
            end else begin
                send_line(LC_EOT); n_st = LS_IDLE; n_enq = 1'b0;
            end
            n_to = '0; res.timer_action = TA_LONG;
        end
    endfunction

    function automatic void tick_idle_wack();
        if (r_to < i_cfg.timeout_limit) begin
            if (r_enq) begin
                n_enq = 1'b0; send_line(LC_WACK); n_to = '0;
            end else n_to = r_to + 8'd1;
            res.timer_action = TA_LONG;
        end else abort_line(RK_TIMEOUT);
    endfunction

    function automatic void tick_count();
        if (r_to < i_cfg.timeout_limit) begin
            n_to = r_to + 8'd1; res.timer_action = TA_LONG;
        end else abort_line(RK_TIMEOUT);
    endfunction

    function automatic void tick_send(input logic [3:0] code);
        if (r_to < i_cfg.timeout_limit) begin
            send_line(code); n_to = r_to + 8'd1; res.timer_action = TA_LONG;
        end else abort_line(RK_TIMEOUT);
    endfunction

    function automatic void retry_enq(input logic [7:0] cnt, input logic [7:0] lim,
                                      output logic ok);
        ok = (cnt < lim);
        if (ok) begin
            send_line(LC_ENQ); n_to = '0; res.timer_action = TA_LONG;
        end else abort_line(RK_RETRY);
    endfunction

    function automatic void rvi_received();
        send_line(LC_EOT);
        res.response_valid = 1'b1; res.response_kind = RK_RVI; res.response_state = r_st;
        res.response_detail = sat15({1'b0, r_sent} + 6'd1);
        n_req = HR_NONE; to_idle();
    endfunction

    function automatic void eot_received(input logic [1:0] req);
        if (r_req == req) begin
            res.response_valid = 1'b1; res.response_kind = RK_EOT;
            res.response_state = r_st;
            res.response_detail = (req == HR_SEND) ? sat15({1'b0, r_sent} + 6'd1)
                                                   : sat15({2'b0, r_rcv} + 6'd1);
            n_req = HR_NONE;
        end
        to_idle();
    endfunction

    function automatic void ack_good();
        logic [4:0] s;
        s = r_sent;
        if (r_req == HR_SEND) begin
            n_req = HR_NONE; n_exp = ~r_exp;
            if (r_sent < 5'd31) s = r_sent + 5'd1;
            n_sent = s;
            if (s == i_cfg.send_block_count) res.response_valid = 1'b1;
        end
        n_st = LS_DONE; n_to = '0; res.timer_action = TA_SHORT;
    endfunction

    function automatic void nak_resend();
        if (r_nakc < i_cfg.nak_retry_limit) begin
            send_block(); n_nakc = r_nakc + 8'd1; n_to = '0; n_st = LS_SENT;
            res.timer_action = TA_LONG;
        end else abort_line(RK_RETRY);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= LS_CLOSED; r_req <= HR_NONE; r_enq <= 1'b0; r_rvi <= 1'b0; r_exp <= 1'b0;
            r_to <= '0; r_ttd <= '0; r_ackc <= '0; r_nakc <= '0; r_wc <= '0;
            r_ptr <= '0; r_crc <= '0; r_sent <= '0; r_rcv <= '0; r_last <= LC_NONE;
        end else if (i_go) begin
            r_st <= n_st; r_req <= n_req; r_enq <= n_enq; r_rvi <= n_rvi; r_exp <= n_exp;
            r_to <= n_to; r_ttd <= n_ttd; r_ackc <= n_ackc; r_nakc <= n_nakc; r_wc <= n_wc;
            r_ptr <= n_ptr; r_crc <= n_crc; r_sent <= n_sent; r_rcv <= n_rcv;
            r_last <= n_last;
        end
    end

    assign o_res = res;

    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PW'(BLOCK_MAX + 1)) else $error("byte pointer past limit");
    a_state_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st <= LS_DONE) else $error("link state out of range");
    a_close_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_go && res.modem_close |=> r_st == LS_CLOSED) else $error("close without closed");
endmodule
`default_nettype wire

// ===== rtl/bsc_link_protocol_engine_top.sv =====
// Top level of the binary synchronous link controller.
// Depends on bsc_pkg, bsc_cfg_regs and bsc_engine.
//
// Usage:
//  - s_axis carries one event per transfer; tdata = {open_status, ack_parity,
//    rx_byte, mode} from the high bit down. Each event gives exactly one result.
//  - m_axis carries the result; tdata packs line_code, block_index,
//    deliver_block, response_valid, response_kind, response_state,
//    response_detail, timer_action, modem_close from the low bit up.
//  - cfg channel writes register i_cfg_index with i_cfg_data; take it only
//    while the block is idle. It is always ready.
//  - Latency: an accepted event's result appears on the next cycle.
//    Throughput: one event per cycle while the receiver keeps tready high; the
//    link state and CRC update for an event are registered together with the
//    result register at the input handshake.
//  - Stall: when the receiver holds tready low the result register holds and
//    the input side is ready only if the result register is empty or drains.
//  - Reset (synchronous, active low): link closed, counters cleared, config at
//    defaults, result register empty. The receive store is not cleared.
`default_nettype none
module bsc_link_protocol_engine_top
    import bsc_pkg::*;
#(
    parameter int BLOCK_MAX  = BLOCK_MAX_DEF,
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // mode[4:0] rx_byte[12:5] ack_parity[13] open_status[21:14]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // line_code, block_index, deliver, rsp_valid, kind, state, detail, timer, close
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [8:0]  i_cfg_data
);
    t_cfg    cfg;
    t_event  ev;
    t_result res;
    t_result r_out;
    logic    r_ov;
    logic    go;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_ov || m_axis_tready;
    assign go            = s_axis_tvalid && s_axis_tready;

    assign ev.mode        = s_axis_tdata[4:0];
    assign ev.rx_byte     = s_axis_tdata[12:5];
    assign ev.ack_parity  = s_axis_tdata[13];
    assign ev.open_status = s_axis_tdata[21:14];

    bsc_cfg_regs u_cfg (
        .i_clk, .i_rst_n, .i_wr(i_cfg_valid), .i_idx(i_cfg_index), .i_data(i_cfg_data),
        .o_cfg(cfg)
    );

    bsc_engine #(.BLOCK_MAX(BLOCK_MAX), .MAX_BLOCKS(MAX_BLOCKS)) u_eng (
        .i_clk, .i_rst_n, .i_go(go), .i_ev(ev), .i_cfg(cfg), .o_res(res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (go) r_ov <= 1'b1;
        else if (m_axis_tready) r_ov <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (go) r_out <= res;
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {3'd0, r_out.modem_close, r_out.timer_action, r_out.response_detail,
                            r_out.response_state, r_out.response_kind, r_out.response_valid,
                            r_out.deliver_block, r_out.block_index, r_out.line_code};
endmodule
`default_nettype wire
